FILE: src/fpalu_pkg.sv
`default_nettype none
package fpalu_pkg;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_INC      = 4'd4,
    CMD_DEC      = 4'd5,
    CMD_MIN      = 4'd6,
    CMD_MAX      = 4'd7,
    CMD_LT       = 4'd8,
    CMD_GT       = 4'd9,
    CMD_LE       = 4'd10,
    CMD_GE       = 4'd11,
    CMD_EQ       = 4'd12,
    CMD_NE       = 4'd13,
    CMD_TO_INT   = 4'd14,
    CMD_FROM_INT = 4'd15
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    status_e            status;
  } alu_rsp_t;

endpackage
`default_nettype wire

FILE: src/fixed_point_q24_8_alu_top.sv
`default_nettype none
// Signed fixed-point ALU, raw 32-bit two's-complement operands with FRAC_BITS
// fraction bits (Q24.8 by default).
// Command channel: a beat (req_i) is taken at a rising edge where start_i is
// high and busy_o is low. busy_o stays low, so a beat may enter every cycle.
// Result channel: rsp_o is valid for exactly one cycle while done_o is high;
// the receiver takes it at the edge ending that cycle and cannot stall.
// Ordering: every command takes the same path, through stages 1 and 2, the
// divider entry, the divider stages and the output register, so results stay
// in order.
// Throughput: one beat per cycle, set by the 32-stage restoring divider,
// one quotient bit per stage, which all commands pass through alongside.
// Multiply uses one 32x32 product in the second stage.
// Reset: rst_ni low clears all stage valid bits; beats in flight are dropped.
// Status: 0 ok, 1 saturated on overflow, 2 divide by zero (result zero).
module fixed_point_q24_8_alu_top #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  output logic                 busy_o,
  input  fpalu_pkg::alu_req_t  req_i,
  output logic                 done_o,
  output fpalu_pkg::alu_rsp_t  rsp_o
);
  import fpalu_pkg::*;

  localparam int unsigned DIV_STEPS = 32;
  localparam logic [63:0] HALF = (FRAC_BITS == 0) ? 64'd0 : (64'd1 << (FRAC_BITS - 1));
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic        div;
    logic        neg;
    logic        dovf;
    logic [63:0] rem;
    logic [32:0] den;
    logic [31:0] quo;
    alu_rsp_t    rsp;
  } div_stage_t;

  function automatic alu_rsp_t sat_mag(logic [63:0] mag, logic neg);
    alu_rsp_t r;
    r.compare_true = 1'b0;
    r.status       = ST_OK;
    r.result_value = '0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.result_value = S_MIN;
        r.status       = ST_OVF;
      end else begin
        r.result_value = signed'(32'd0 - mag[31:0]);
      end
    end else if (mag > 64'h7fff_ffff) begin
      r.result_value = S_MAX;
      r.status       = ST_OVF;
    end else begin
      r.result_value = signed'(mag[31:0]);
    end
    return r;
  endfunction

  function automatic alu_rsp_t sat_sum(logic signed [32:0] s);
    alu_rsp_t r;
    r.compare_true = 1'b0;
    r.status       = ST_OK;
    r.result_value = s[31:0];
    if (s[32] != s[31]) begin
      r.result_value = s[32] ? S_MIN : S_MAX;
      r.status       = ST_OVF;
    end
    return r;
  endfunction

  // stage 1: operands and magnitudes
  logic               v1_q;
  cmd_e               cmd1_q;
  logic signed [31:0] a1_q, b1_q;
  logic [31:0]        ma1_q, mb1_q;

  // stage 2: product, divider setup, simple results
  logic        v2_q;
  cmd_e        cmd2_q;
  logic        neg2_q, div2_q;
  logic [63:0] prod2_q, num2_q;
  logic [32:0] den2_q;
  alu_rsp_t    rsp2_q, rsp2_d;

  logic               stg_v_q [DIV_STEPS+1];
  div_stage_t         stg_q   [DIV_STEPS+1];

  logic     done_q;
  alu_rsp_t rsp_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q <= req_i.command;
    a1_q   <= req_i.operand_a;
    b1_q   <= req_i.operand_b;
    ma1_q  <= req_i.operand_a[31] ? 32'd0 - req_i.operand_a : req_i.operand_a;
    mb1_q  <= req_i.operand_b[31] ? 32'd0 - req_i.operand_b : req_i.operand_b;
  end

  always_comb begin
    rsp2_d.result_value = '0;
    rsp2_d.compare_true = 1'b0;
    rsp2_d.status       = ST_OK;
    unique case (cmd1_q)
      CMD_ADD:      rsp2_d = sat_sum({a1_q[31], a1_q} + {b1_q[31], b1_q});
      CMD_SUB:      rsp2_d = sat_sum({a1_q[31], a1_q} - {b1_q[31], b1_q});
      CMD_INC:      rsp2_d = sat_sum({a1_q[31], a1_q} + 33'sd1);
      CMD_DEC:      rsp2_d = sat_sum({a1_q[31], a1_q} - 33'sd1);
      CMD_MIN:      rsp2_d.result_value = (a1_q < b1_q) ? a1_q : b1_q;
      CMD_MAX:      rsp2_d.result_value = (a1_q > b1_q) ? a1_q : b1_q;
      CMD_LT:       rsp2_d.compare_true = a1_q < b1_q;
      CMD_GT:       rsp2_d.compare_true = a1_q > b1_q;
      CMD_LE:       rsp2_d.compare_true = a1_q <= b1_q;
      CMD_GE:       rsp2_d.compare_true = a1_q >= b1_q;
      CMD_EQ:       rsp2_d.compare_true = a1_q == b1_q;
      CMD_NE:       rsp2_d.compare_true = a1_q != b1_q;
      CMD_TO_INT:   rsp2_d.result_value = a1_q >>> FRAC_BITS;
      CMD_FROM_INT: rsp2_d = sat_mag(64'(ma1_q) << FRAC_BITS, a1_q[31]);
      CMD_DIV: begin
        if (b1_q == 32'sd0) begin
          rsp2_d.status = ST_DZ;
        end
      end
      CMD_MUL: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd2_q  <= cmd1_q;
    neg2_q  <= a1_q[31] ^ b1_q[31];
    div2_q  <= (cmd1_q == CMD_DIV) && (b1_q != 32'sd0);
    prod2_q <= 64'(ma1_q) * 64'(mb1_q);
    num2_q  <= ((64'(ma1_q) << FRAC_BITS) << 1) + 64'(mb1_q);
    den2_q  <= {mb1_q, 1'b0};
    rsp2_q  <= rsp2_d;
  end

  // stage 3: multiply rounding, divider entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q[0] <= 1'b0;
    end else begin
      stg_v_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q[0].div  <= div2_q;
    stg_q[0].neg  <= neg2_q;
    stg_q[0].dovf <= {1'b0, num2_q} >= {den2_q, 32'd0};
    stg_q[0].rem  <= num2_q;
    stg_q[0].den  <= den2_q;
    stg_q[0].quo  <= '0;
    stg_q[0].rsp  <= (cmd2_q == CMD_MUL) ? sat_mag((prod2_q + HALF) >> FRAC_BITS, neg2_q)
                                         : rsp2_q;
  end

  // divider: one quotient bit per stage, most significant first
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [63:0] trial;
    logic        take;
    div_stage_t  stg_d;
    assign trial = 64'(stg_q[j].den) << (DIV_STEPS - 1 - j);
    assign take  = stg_q[j].rem >= trial;

    always_comb begin
      stg_d     = stg_q[j];
      stg_d.rem = take ? stg_q[j].rem - trial : stg_q[j].rem;
      stg_d.quo[DIV_STEPS-1-j] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_v_q[j+1] <= 1'b0;
      end else begin
        stg_v_q[j+1] <= stg_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[j+1] <= stg_d;
    end
  end

  // output: divide sign and saturation, select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stg_v_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_q[DIV_STEPS].div) begin
      rsp_q <= sat_mag(stg_q[DIV_STEPS].dovf ? 64'h1_0000_0000
                                             : 64'(stg_q[DIV_STEPS].quo),
                       stg_q[DIV_STEPS].neg);
    end else begin
      rsp_q <= stg_q[DIV_STEPS].rsp;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##36 done_o)
    else $error("result beat missing at fixed latency");
  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.compare_true) |-> (rsp_o.result_value == 32'sd0 && rsp_o.status == ST_OK))
    else $error("compare beat carries a value or status");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_DZ) |-> (rsp_o.result_value == 32'sd0 && !rsp_o.compare_true))
    else $error("divide by zero beat not zero");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(stg_v_q[DIV_STEPS]))
    else $error("result beat without a beat in flight");
`endif

endmodule
`default_nettype wire

FILE: sim/fixed_point_q24_8_alu_top_tb.sv
module fixed_point_q24_8_alu_top_tb;
  import fpalu_pkg::*;

  localparam int FRAC = 8;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic done_o;
  alu_req_t req_i = '0;
  alu_rsp_t rsp_o;

  alu_req_t pending_q[$];
  alu_rsp_t expected_q[$];
  int errors = 0;
  int idle_pct = 35;
  bit hold = 1'b0;

  fixed_point_q24_8_alu_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v,
                                               inout status_e st);
    if (v > S32_MAX) begin
      st = ST_OVF;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      st = ST_OVF;
      return S32_MIN;
    end
    return v;
  endfunction

  function automatic alu_rsp_t alu_predict(input alu_req_t rq);
    alu_rsp_t rs;
    logic signed [63:0] a, b, r;
    logic [63:0] ma, mb, q;
    status_e st;
    bit neg;
    a = 64'(rq.operand_a);
    b = 64'(rq.operand_b);
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    neg = a[63] != b[63];
    r = 0;
    st = ST_OK;
    rs = '0;
    case (rq.command)
      CMD_ADD: r = sat32(a + b, st);
      CMD_SUB: r = sat32(a - b, st);
      CMD_MUL: begin
        q = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
        r = sat32(neg ? -$signed(q) : $signed(q), st);
      end
      CMD_DIV: begin
        if (b == 0) begin
          st = ST_DZ;
        end else begin
          q = (2 * (ma << FRAC) + mb) / (2 * mb);
          r = sat32(neg ? -$signed(q) : $signed(q), st);
        end
      end
      CMD_INC: r = sat32(a + 1, st);
      CMD_DEC: r = sat32(a - 1, st);
      CMD_MIN: r = (a < b) ? a : b;
      CMD_MAX: r = (a > b) ? a : b;
      CMD_LT: rs.compare_true = a < b;
      CMD_GT: rs.compare_true = a > b;
      CMD_LE: rs.compare_true = a <= b;
      CMD_GE: rs.compare_true = a >= b;
      CMD_EQ: rs.compare_true = a == b;
      CMD_NE: rs.compare_true = a != b;
      CMD_TO_INT: r = a >>> FRAC;
      default: r = sat32(a[63] ? -$signed(ma << FRAC) : $signed(ma << FRAC), st);
    endcase
    rs.result_value = r[31:0];
    rs.status = st;
    return rs;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 4)) - 2);
      3: return 32'($signed($urandom_range(0, 4096)) - 2048);
      4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      expected_q.push_back(alu_predict(req_i));
      void'(pending_q.pop_front());
    end
    if (pending_q.size() != 0 && !hold && $urandom_range(0, 99) >= idle_pct) begin
      start_i <= 1'b1;
      req_i <= pending_q[0];
    end else begin
      start_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    alu_rsp_t e;
    if (done_o) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (rsp_o.result_value !== e.result_value) begin
          $error("result_value expected %h actual %h", e.result_value, rsp_o.result_value);
          errors++;
        end
        if (rsp_o.compare_true !== e.compare_true) begin
          $error("compare_true expected %b actual %b", e.compare_true, rsp_o.compare_true);
          errors++;
        end
        if (rsp_o.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, rsp_o.status);
          errors++;
        end
      end
    end
  end

  task automatic add_beat(input cmd_e c, input logic [31:0] a, input logic [31:0] b);
    alu_req_t rq;
    rq.command = c;
    rq.operand_a = a;
    rq.operand_b = b;
    pending_q.push_back(rq);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || start_i) @(posedge clk_i);
  endtask

  initial begin
    cmd_e c;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 16; i++) begin
      c = cmd_e'(i);
      add_beat(c, 32'h7fffffff, 32'h80000000);
    end
    add_beat(CMD_DIV, 32'h00000100, 32'h0);
    add_beat(CMD_MUL, 32'h00000180, 32'h00000001);
    add_beat(CMD_MUL, 32'hfffffe80, 32'h00000001);
    add_beat(CMD_DIV, 32'h00000001, 32'h00000200);
    add_beat(CMD_TO_INT, 32'hffffff01, 32'h0);
    add_beat(CMD_FROM_INT, 32'h00800000, 32'h0);
    add_beat(CMD_FROM_INT, 32'hff800000, 32'h0);
    add_beat(CMD_DEC, 32'h80000000, 32'h0);
    add_beat(CMD_EQ, 32'h0, 32'h0);
    drain();
    hold = 1'b1;
    while (expected_q.size() != 0) @(posedge clk_i);
    hold = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 35 : (ph == 1) ? 65 : 0;
      for (int i = 0; i < 370; i++) begin
        c = cmd_e'($urandom_range(0, 15));
        add_beat(c, pick_operand(), pick_operand());
      end
      drain();
    end
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("fixed_point_q24_8_alu_top_tb: clean");
    end else begin
      $display("fixed_point_q24_8_alu_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("fixed_point_q24_8_alu_top_tb: errors");
    $finish;
  end
endmodule
